/* design/superfasthash_bucket_index_macros.svh */
// ----------------------------------------------------------------------------
// superfasthash_bucket_index_macros
// assertion shorthands shared by the hash block
// ----------------------------------------------------------------------------
`ifndef SUPERFASTHASH_BUCKET_INDEX_MACROS_SVH
`define SUPERFASTHASH_BUCKET_INDEX_MACROS_SVH

// clocked check, muted while reset is high
`define SFH_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked check that also holds through reset
`define SFH_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* design/sfh_pkg.sv */
// ----------------------------------------------------------------------------
// sfh_pkg
// types, constants and micro-op program for the hash bucket index block
// ----------------------------------------------------------------------------
package sfh_pkg;

   localparam int HASH_W  = 32;
   localparam int UPC_W   = 5;
   localparam int KLEN_W  = 16;
   localparam int NBYTE_W = 3;

   localparam logic [UPC_W-1:0] MAIN_START  = 5'd0;
   localparam logic [UPC_W-1:0] TAIL3_START = 5'd4;
   localparam logic [UPC_W-1:0] TAIL2_START = 5'd8;
   localparam logic [UPC_W-1:0] TAIL1_START = 5'd11;
   localparam logic [UPC_W-1:0] AVAL_START  = 5'd14;
   localparam logic [UPC_W-1:0] UOP_COUNT   = 5'd20;

   localparam logic [NBYTE_W-1:0] FULL_CHUNK = 3'd4;

   typedef enum logic [0:0] {
      ALU_ADD = 1'b0,
      ALU_XOR = 1'b1
   } alu_op_type;

   typedef enum logic [2:0] {
      SRC_SHL  = 3'd0,   // h << amt
      SRC_SHR  = 3'd1,   // h >> amt
      SRC_LO   = 3'd2,   // low half of chunk
      SRC_HI11 = 3'd3,   // high half of chunk << 11
      SRC_B2   = 3'd4,   // signed byte 2 << 18
      SRC_B0   = 3'd5    // signed byte 0
   } src_type;

   typedef enum logic [1:0] {
      FLOW_STEP  = 2'd0,
      FLOW_CHAIN = 2'd1,  // end of a mixing round
      FLOW_DIV   = 2'd2   // end of avalanche
   } flow_type;

   typedef struct packed {
      alu_op_type op;
      src_type    src;
      logic [4:0] amt;
      flow_type   flow;
   } uop_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

   function automatic uop_type uop_rom(logic [UPC_W-1:0] pc);
      uop_type u;
      unique case (pc)
         // main round
         5'd0:    u = '{ALU_ADD, SRC_LO,   5'd0,  FLOW_STEP};
         5'd1:    u = '{ALU_XOR, SRC_SHL,  5'd16, FLOW_STEP};
         5'd2:    u = '{ALU_XOR, SRC_HI11, 5'd0,  FLOW_STEP};
         5'd3:    u = '{ALU_ADD, SRC_SHR,  5'd11, FLOW_CHAIN};
         // three byte tail
         5'd4:    u = '{ALU_ADD, SRC_LO,   5'd0,  FLOW_STEP};
         5'd5:    u = '{ALU_XOR, SRC_SHL,  5'd16, FLOW_STEP};
         5'd6:    u = '{ALU_XOR, SRC_B2,   5'd0,  FLOW_STEP};
         5'd7:    u = '{ALU_ADD, SRC_SHR,  5'd11, FLOW_CHAIN};
         // two byte tail
         5'd8:    u = '{ALU_ADD, SRC_LO,   5'd0,  FLOW_STEP};
         5'd9:    u = '{ALU_XOR, SRC_SHL,  5'd11, FLOW_STEP};
         5'd10:   u = '{ALU_ADD, SRC_SHR,  5'd17, FLOW_CHAIN};
         // one byte tail
         5'd11:   u = '{ALU_ADD, SRC_B0,   5'd0,  FLOW_STEP};
         5'd12:   u = '{ALU_XOR, SRC_SHL,  5'd10, FLOW_STEP};
         5'd13:   u = '{ALU_ADD, SRC_SHR,  5'd1,  FLOW_CHAIN};
         // avalanche
         5'd14:   u = '{ALU_XOR, SRC_SHL,  5'd3,  FLOW_STEP};
         5'd15:   u = '{ALU_ADD, SRC_SHR,  5'd5,  FLOW_STEP};
         5'd16:   u = '{ALU_XOR, SRC_SHL,  5'd4,  FLOW_STEP};
         5'd17:   u = '{ALU_ADD, SRC_SHR,  5'd17, FLOW_STEP};
         5'd18:   u = '{ALU_XOR, SRC_SHL,  5'd25, FLOW_STEP};
         5'd19:   u = '{ALU_ADD, SRC_SHR,  5'd6,  FLOW_DIV};
         default: u = '{ALU_ADD, SRC_SHR,  5'd0,  FLOW_DIV};
      endcase
      return u;
   endfunction

   // entry point for the end-of-key round given the partial byte count
   function automatic logic [UPC_W-1:0] tail_entry(logic [NBYTE_W-1:0] n);
      logic [UPC_W-1:0] pc;
      unique case (n)
         3'd1:    pc = TAIL1_START;
         3'd2:    pc = TAIL2_START;
         3'd3:    pc = TAIL3_START;
         default: pc = AVAL_START;
      endcase
      return pc;
   endfunction

endpackage

/* design/sfh_req_if.sv */
// ----------------------------------------------------------------------------
// sfh_req_if
// key chunk channel, valid/ready handshake
// ----------------------------------------------------------------------------
interface sfh_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] chunk;
   logic [2:0]  chunk_bytes;
   logic        first_chunk;
   logic        last_chunk;
   logic [15:0] key_length;

   modport source (
      output valid, chunk, chunk_bytes, first_chunk, last_chunk, key_length,
      input  ready
   );
   modport sink (
      input  valid, chunk, chunk_bytes, first_chunk, last_chunk, key_length,
      output ready
   );
endinterface

/* design/sfh_rsp_if.sv */
// ----------------------------------------------------------------------------
// sfh_rsp_if
// bucket index result channel, valid/ready handshake
// ----------------------------------------------------------------------------
interface sfh_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] bucket;

   modport source (output valid, bucket, input ready);
   modport sink   (input valid, bucket, output ready);
endinterface

/* design/sfh_step_alu.sv */
// ----------------------------------------------------------------------------
// sfh_step_alu
// shared mixing step: h = h (+|^) operand, one micro-op per cycle
// ----------------------------------------------------------------------------
module sfh_step_alu
   import sfh_pkg::*;
(
   input  logic [HASH_W-1:0] hash,
   input  logic [31:0]       chunk,
   input  uop_type           uop,
   output logic [HASH_W-1:0] result
);

   logic [HASH_W-1:0] operand;

   always_comb begin
      unique case (uop.src)
         SRC_SHL:  operand = hash << uop.amt;
         SRC_SHR:  operand = hash >> uop.amt;
         SRC_LO:   operand = {16'd0, chunk[15:0]};
         SRC_HI11: operand = {5'd0, chunk[31:16], 11'd0};
         SRC_B2:   operand = {{6{chunk[23]}}, chunk[23:16], 18'd0};
         SRC_B0:   operand = {{24{chunk[7]}}, chunk[7:0]};
         default:  operand = '0;
      endcase
   end

   always_comb begin
      unique case (uop.op)
         ALU_ADD: result = hash + operand;
         ALU_XOR: result = hash ^ operand;
         default: result = hash;
      endcase
   end

endmodule

/* design/sfh_divider.sv */
// ----------------------------------------------------------------------------
// sfh_divider
// restoring divider, remainder only, one quotient bit per cycle
// ----------------------------------------------------------------------------
module sfh_divider
   import sfh_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [HASH_W-1:0]   dividend,
   input  logic [HASH_W-1:0]   divisor,
   output div_status_type      status,
   output logic [HASH_W-1:0]   remainder
);

   localparam int CNT_W = $clog2(HASH_W);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [HASH_W-1:0]   quot_ff, quot_in;
   logic [HASH_W-1:0]   rem_ff, rem_in;
   logic [HASH_W-1:0]   dvs_ff, dvs_in;
   logic [HASH_W:0]     trial;
   logic [HASH_W:0]     diff;

   assign trial = {rem_ff, quot_ff[HASH_W-1]};
   assign diff  = trial - {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = done_ff;
      cnt_in  = cnt_ff;
      quot_in = quot_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         done_in = 1'b0;
         cnt_in  = '0;
         quot_in = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         // a zero divisor always subtracts nothing, leaving the dividend
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = diff[HASH_W-1:0];
         end else begin
            rem_in = trial[HASH_W-1:0];
         end
         quot_in = {quot_ff[HASH_W-2:0], 1'b0};
         cnt_in  = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(HASH_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign remainder   = rem_ff;

endmodule

/* design/superfasthash_bucket_index.sv */
// ----------------------------------------------------------------------------
// superfasthash_bucket_index
// 32-bit streaming key hash reduced to a bucket index modulo the table size
// ----------------------------------------------------------------------------
//  channel  direction  payload
//  req      in         chunk, chunk_bytes, first_chunk, last_chunk, key_length
//  rsp      out        bucket
//  csr      in         table_size write (write enable + data)
//
//  A partial chunk that is not last is taken without a mixing step; a full
//  chunk that is not last is transferred, then runs four steps of the shared mixing unit.
//  A last chunk runs up to four tail steps and six avalanche steps on that
//  unit, then the bit-serial divider.
//  req.ready is high only while the sequencer idles; a waiting result in the
//  output register does not block the next chunk, only the next result load.
//  Synchronous reset sets table_size to 1024 and clears hash and control.
// ----------------------------------------------------------------------------
`include "superfasthash_bucket_index_macros.svh"

module superfasthash_bucket_index
   import sfh_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   sfh_req_if.sink           req,
   sfh_rsp_if.source         rsp,
   input  logic              csr_write_en,
   input  logic [HASH_W-1:0] csr_write_data
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_RUN  = 3'b010,
      ST_DIV  = 3'b100
   } state_type;

   state_type           state_ff, state_in;
   logic [UPC_W-1:0]    upc_ff, upc_in;
   logic [HASH_W-1:0]   hash_ff, hash_in;
   logic [31:0]         chunk_ff, chunk_in;
   logic                last_ff, last_in;
   logic                key_empty_ff, key_empty_in;
   logic [HASH_W-1:0]   table_size_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [HASH_W-1:0]   rsp_bucket_ff, rsp_bucket_in;

   logic                req_xfer;
   logic [NBYTE_W-1:0]  nbytes;
   uop_type             uop;
   logic [HASH_W-1:0]   alu_hash;
   logic                div_start;
   div_status_type      div_status;
   logic [HASH_W-1:0]   div_rem;
   logic                rsp_free;

   assign req.ready = (state_ff == ST_IDLE);
   assign req_xfer  = req.valid && req.ready;
   assign nbytes    = (req.chunk_bytes > FULL_CHUNK) ? FULL_CHUNK : req.chunk_bytes;
   assign uop       = uop_rom(upc_ff);
   assign rsp_free  = !rsp_valid_ff || rsp.ready;

   sfh_step_alu u_alu (
      .hash   (hash_ff),
      .chunk  (chunk_ff),
      .uop    (uop),
      .result (alu_hash)
   );

   sfh_divider u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (alu_hash),
      .divisor   (table_size_ff),
      .status    (div_status),
      .remainder (div_rem)
   );

   always_comb begin
      state_in      = state_ff;
      upc_in        = upc_ff;
      hash_in       = hash_ff;
      chunk_in      = chunk_ff;
      last_in       = last_ff;
      key_empty_in  = key_empty_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_bucket_in = rsp_bucket_ff;
      div_start     = 1'b0;

      if (rsp.valid && rsp.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               chunk_in = req.chunk;
               last_in  = req.last_chunk;
               if (req.first_chunk) begin
                  hash_in      = {{(HASH_W-KLEN_W){1'b0}}, req.key_length};
                  key_empty_in = (req.key_length == '0);
               end
               if (nbytes == FULL_CHUNK) begin
                  upc_in   = MAIN_START;
                  state_in = ST_RUN;
               end else if (req.last_chunk) begin
                  upc_in   = tail_entry(nbytes);
                  state_in = ST_RUN;
               end
            end
         end
         ST_RUN: begin
            hash_in = alu_hash;
            unique case (uop.flow)
               FLOW_STEP: upc_in = upc_ff + 1'b1;
               FLOW_CHAIN: begin
                  if (last_ff) begin
                     upc_in = AVAL_START;
                  end else begin
                     state_in = ST_IDLE;
                  end
               end
               default: begin
                  div_start = 1'b1;
                  state_in  = ST_DIV;
               end
            endcase
         end
         ST_DIV: begin
            // hold the remainder in the divider until the output slot frees
            if (div_status.done && rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_bucket_in = key_empty_ff ? '0 : div_rem;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         upc_ff        <= '0;
         hash_ff       <= '0;
         key_empty_ff  <= 1'b0;
         last_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         table_size_ff <= 32'd1024;
      end else begin
         state_ff      <= state_in;
         upc_ff        <= upc_in;
         hash_ff       <= hash_in;
         key_empty_ff  <= key_empty_in;
         last_ff       <= last_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_write_en) begin
            table_size_ff <= csr_write_data;
         end
      end
      chunk_ff      <= chunk_in;
      rsp_bucket_ff <= rsp_bucket_in;
   end

   assign rsp.valid  = rsp_valid_ff;
   assign rsp.bucket = rsp_bucket_ff;

   `SFH_ASSERT(a_div_busy_in_div, clock, reset, div_status.busy |-> state_ff == ST_DIV, "divider busy")
   `SFH_ASSERT(a_div_start_idle, clock, reset, div_start |-> !div_status.busy, "divider restarted")
   `SFH_ASSERT(a_upc_range, clock, reset, state_ff == ST_RUN |-> upc_ff < UOP_COUNT, "upc range")
   `SFH_ASSERT(a_no_overwrite, clock, reset, (rsp_valid_ff && !rsp.ready) |=> rsp_valid_ff, "result dropped")

endmodule
